FILE: design/mtdt_pkg.sv
// ----------------------------------------------------------------------------
// mtdt_pkg: shared types and constants of the timer bank
// Request codes, register indexes, the stored timer entry and its update rule.
// ----------------------------------------------------------------------------
package mtdt_pkg;

  localparam int REQ_W     = 2;
  localparam int BANK_W    = 2;
  localparam int TIDX_W    = 4;
  localparam int PRESET_W  = 16;
  localparam int COUNT_W   = 15;
  localparam int LIMIT_W   = 12;
  localparam int CFG_IDX_W = 2;
  localparam int NUM_BANKS = 4;

  // Request codes
  localparam logic [REQ_W-1:0] REQ_TICK  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_START = 2'd1;
  localparam logic [REQ_W-1:0] REQ_STOP  = 2'd2;
  localparam logic [REQ_W-1:0] REQ_READ  = 2'd3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT1 = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT2 = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT3 = 2'd2;

  localparam logic [LIMIT_W-1:0] LIMIT1_RST = 12'd10;
  localparam logic [LIMIT_W-1:0] LIMIT2_RST = 12'd100;
  localparam logic [LIMIT_W-1:0] LIMIT3_RST = 12'd1000;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  typedef struct packed {
    logic [PRESET_W-1:0] preset;
    logic [COUNT_W-1:0]  count;
    logic                enable;
    logic                done;
  } timer_entry_t;

  localparam int ENTRY_W = $bits(timer_entry_t);

  typedef struct packed {
    logic               done;
    logic [COUNT_W-1:0] count;
    logic               running;
  } timer_result_t;

  // Prescalers that reached their limit on this tick
  typedef struct packed {
    logic bank1;
    logic bank2;
    logic bank3;
  } prescale_hit_t;

  // One timebase step of a timer
  function automatic timer_entry_t entry_tick(timer_entry_t e);
    timer_entry_t r;
    r = e;
    if (e.enable) begin
      r.done = ($signed({1'b0, e.count}) >= $signed(e.preset));
      if (e.count != COUNT_MAX) begin
        r.count = e.count + 15'd1;
      end else begin
        r.done = 1'b0;
      end
    end
    return r;
  endfunction

endpackage

FILE: design/mtdt_if.sv
// ----------------------------------------------------------------------------
// mtdt_if: channel interfaces of the timer bank
// Request, response and configuration channels, each with valid and ready.
// ----------------------------------------------------------------------------
interface mtdt_req_if;
  logic                                valid;
  logic                                ready;
  logic        [mtdt_pkg::REQ_W-1:0]    req_type;
  logic        [mtdt_pkg::BANK_W-1:0]   bank_sel;
  logic        [mtdt_pkg::TIDX_W-1:0]   timer_index;
  logic signed [mtdt_pkg::PRESET_W-1:0] preset_value;

  modport source (output valid, req_type, bank_sel, timer_index, preset_value,
                  input ready);
  modport sink   (input valid, req_type, bank_sel, timer_index, preset_value,
                  output ready);
endinterface

interface mtdt_rsp_if;
  logic                           valid;
  logic                           ready;
  logic                           timer_done;
  logic [mtdt_pkg::COUNT_W-1:0]   timer_count;
  logic                           timer_running;

  modport source (output valid, timer_done, timer_count, timer_running,
                  input ready);
  modport sink   (input valid, timer_done, timer_count, timer_running,
                  output ready);
endinterface

interface mtdt_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [mtdt_pkg::CFG_IDX_W-1:0] index;
  logic [mtdt_pkg::LIMIT_W-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: design/mtdt_ram.sv
// ----------------------------------------------------------------------------
// mtdt_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module mtdt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: design/mtdt_prescale.sv
// ----------------------------------------------------------------------------
// mtdt_prescale: timebase prescalers and limit registers
// Holds the three limit registers and flags which slow banks a tick updates.
// ----------------------------------------------------------------------------
module mtdt_prescale (
  input  logic                    clk,
  input  logic                    rst,
  mtdt_cfg_if.sink                cfg,
  input  logic                    tick_take,
  output mtdt_pkg::prescale_hit_t hits
);
  import mtdt_pkg::*;

  logic [LIMIT_W-1:0] limit1, limit2, limit3;
  logic [LIMIT_W-1:0] pre_a, pre_b, pre_c;

  assign cfg.ready = 1'b1;

  // Compare each prescaler against its limit
  assign hits.bank1 = (pre_a >= limit1);
  assign hits.bank2 = (pre_b >= limit2);
  assign hits.bank3 = (pre_c >= limit3);

  // Limit registers
  always_ff @(posedge clk) begin
    if (rst) begin
      limit1 <= LIMIT1_RST;
      limit2 <= LIMIT2_RST;
      limit3 <= LIMIT3_RST;
    end else if (cfg.valid) begin
      case (cfg.index)
        CFG_LIMIT1: limit1 <= cfg.data;
        CFG_LIMIT2: limit2 <= cfg.data;
        CFG_LIMIT3: limit3 <= cfg.data;
        default: ;
      endcase
    end
  end

  // Clear on hit, then advance all prescalers on every tick
  always_ff @(posedge clk) begin
    if (rst) begin
      pre_a <= '0;
      pre_b <= '0;
      pre_c <= '0;
    end else if (tick_take) begin
      pre_a <= (hits.bank1 ? '0 : pre_a) + 12'd1;
      pre_b <= (hits.bank2 ? '0 : pre_b) + 12'd1;
      pre_c <= (hits.bank3 ? '0 : pre_c) + 12'd1;
    end
  end

endmodule

FILE: design/mtdt_seq.sv
// ----------------------------------------------------------------------------
// mtdt_seq: timer store sequencer
// Clears the timer store after reset, walks it on ticks and does a
// read-modify-write for start, stop and read requests.
// ----------------------------------------------------------------------------
module mtdt_seq #(
  parameter int TIMERS_PER_BANK = 16
) (
  input  logic                    clk,
  input  logic                    rst,
  mtdt_req_if.sink                req,
  mtdt_rsp_if.source              rsp,
  input  mtdt_pkg::prescale_hit_t hits,
  output logic                    tick_take
);
  import mtdt_pkg::*;

  localparam int IDX_W = (TIMERS_PER_BANK > 1) ? $clog2(TIMERS_PER_BANK) : 1;
  localparam int AW    = IDX_W + BANK_W;
  localparam int DEPTH = 1 << AW;
  localparam int XW    = (IDX_W > TIDX_W) ? IDX_W : TIDX_W;

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_TICK  = 3'd2;
  localparam logic [2:0] ST_READ  = 3'd3;
  localparam logic [2:0] ST_MOD   = 3'd4;
  localparam logic [2:0] ST_OUT   = 3'd5;

  logic [2:0]           state;
  logic [AW-1:0]        clr_ptr;
  logic [AW-1:0]        rd_ptr;
  logic                 rd_active;
  logic                 wb_valid;
  logic [AW-1:0]        wb_addr;
  logic [NUM_BANKS-1:0] bank_upd;
  logic                 out_valid;

  logic [REQ_W-1:0]     it_req;
  logic [AW-1:0]        it_addr;
  logic [PRESET_W-1:0]  it_preset;
  timer_result_t        res;
  timer_result_t        out_data;

  logic                 accept;
  logic                 in_range;
  logic [XW-1:0]        idx_wide;
  logic [AW-1:0]        in_addr;
  logic                 out_free;

  logic                 mem_we;
  logic [AW-1:0]        mem_waddr;
  logic [ENTRY_W-1:0]   mem_wdata;
  logic                 mem_re;
  logic [AW-1:0]        mem_raddr;
  logic [ENTRY_W-1:0]   mem_rdata;

  timer_entry_t         rd_entry;
  timer_entry_t         mod_entry;
  timer_entry_t         tick_entry;

  mtdt_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Handshake and request decode
  assign req.ready = (state == ST_IDLE);
  assign accept    = req.valid && req.ready;
  assign tick_take = accept && (req.req_type == REQ_TICK);
  assign in_range  = (int'(req.timer_index) < TIMERS_PER_BANK);
  assign idx_wide  = XW'(req.timer_index);
  assign in_addr   = {req.bank_sel, idx_wide[IDX_W-1:0]};
  assign out_free  = !out_valid || rsp.ready;

  assign rsp.valid         = out_valid;
  assign rsp.timer_done    = out_data.done;
  assign rsp.timer_count   = out_data.count;
  assign rsp.timer_running = out_data.running;

  assign rd_entry = timer_entry_t'(mem_rdata);

  // Apply start or stop to the addressed entry
  always_comb begin
    mod_entry = rd_entry;
    unique case (it_req)
      REQ_START: begin
        if (!rd_entry.enable) begin
          mod_entry.preset = it_preset;
          mod_entry.count  = '0;
          mod_entry.enable = 1'b1;
          mod_entry.done   = 1'b0;
        end
      end
      REQ_STOP: begin
        if (rd_entry.enable) begin
          mod_entry.enable = 1'b0;
          mod_entry.done   = 1'b0;
        end
      end
      REQ_READ, REQ_TICK: mod_entry = rd_entry;
    endcase
  end

  // Step the entry only if its bank is due on this tick
  assign tick_entry = bank_upd[wb_addr[AW-1 -: BANK_W]] ? entry_tick(rd_entry) : rd_entry;

  // Memory port steering
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = clr_ptr;
    mem_wdata = '0;
    mem_re    = 1'b0;
    mem_raddr = rd_ptr;
    unique case (state)
      ST_CLEAR: mem_we = 1'b1;
      ST_TICK: begin
        mem_re    = rd_active;
        mem_we    = wb_valid;
        mem_waddr = wb_addr;
        mem_wdata = tick_entry;
      end
      ST_READ: begin
        mem_re    = 1'b1;
        mem_raddr = it_addr;
      end
      ST_MOD: begin
        mem_we    = 1'b1;
        mem_waddr = it_addr;
        mem_wdata = mod_entry;
      end
      default: ;
    endcase
  end

  // Sequencer control
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_ptr   <= '0;
      rd_ptr    <= '0;
      rd_active <= 1'b0;
      wb_valid  <= 1'b0;
      bank_upd  <= '0;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        ST_CLEAR: begin
          clr_ptr <= clr_ptr + 1'b1;
          if (&clr_ptr) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            priority if (req.req_type == REQ_TICK) begin
              state     <= ST_TICK;
              rd_ptr    <= '0;
              rd_active <= 1'b1;
              wb_valid  <= 1'b0;
              bank_upd  <= {hits.bank3, hits.bank2, hits.bank1, 1'b1};
            end else if (!in_range) begin
              state <= ST_OUT;
            end else begin
              state <= ST_READ;
            end
          end
        end
        ST_TICK: begin
          if (rd_active) begin
            rd_ptr <= rd_ptr + 1'b1;
            if (&rd_ptr) begin
              rd_active <= 1'b0;
            end
          end
          wb_valid <= rd_active;
          if (!rd_active && wb_valid) begin
            state <= ST_OUT;
          end
        end
        ST_READ: state <= ST_MOD;
        ST_MOD:  state <= ST_OUT;
        ST_OUT: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase

      // Load a finished result, drop it once taken
      if (state == ST_OUT && out_free) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Request capture, write-back address and result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      it_req    <= req.req_type;
      it_addr   <= in_addr;
      it_preset <= req.preset_value;
      res       <= '0;
    end
    if (state == ST_TICK) begin
      wb_addr <= rd_ptr;
    end
    if (state == ST_MOD) begin
      res.done    <= mod_entry.done;
      res.count   <= mod_entry.count;
      res.running <= mod_entry.enable;
    end
    if (state == ST_OUT && out_free) begin
      out_data <= res;
    end
  end

  // Never read and write the same entry in one cycle
  a_no_rw_overlap: assert property (@(posedge clk) disable iff (rst)
    (mem_we && mem_re) |-> (mem_waddr != mem_raddr))
    else $error("timer store read and write hit the same entry");

  // Tick write-back goes to the entry read in the cycle before
  a_wb_follows_rd: assert property (@(posedge clk) disable iff (rst)
    (state == ST_TICK && wb_valid) |-> (wb_addr == $past(rd_ptr)))
    else $error("tick write-back address out of step with read");

  // Modify only right after the read of the same request
  a_mod_after_read: assert property (@(posedge clk) disable iff (rst)
    (state == ST_MOD) |-> ($past(state) == ST_READ))
    else $error("modify without preceding read");

  // A pending result is never overwritten
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (state == ST_OUT && out_valid && !rsp.ready) |=> (state == ST_OUT))
    else $error("result dropped while response stalled");

endmodule

FILE: design/multi_timebase_on_delay_timer_bank_top.sv
// ----------------------------------------------------------------------------
// multi_timebase_on_delay_timer_bank_top: four banks of on-delay timers
// Timebases of 1, 10, 100 and 1000 ticks by default, state held in one timer RAM.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one request: tick, start, stop or read of a timer addressed
//   by bank_sel and timer_index. rsp returns one result per request: the
//   addressed timer's done, count and running bits after the request (all
//   zero for a tick or an index beyond the bank). cfg writes the three
//   prescaler limit registers; it is always ready. The user must write it
//   only while the block is idle; the block itself does not enforce this.
//   Start, stop and read pass from acceptance to rsp.valid through read,
//   modify and write back, and load result; an index beyond the bank goes
//   straight to load result. A tick walks every timer RAM entry (4 times
//   TIMERS_PER_BANK rounded up to a power of two), one per cycle. One
//   request is in flight at a time. After reset the timer RAM is cleared
//   one entry a cycle; req.ready stays low meanwhile. When rsp stalls, a
//   finished result holds in the output register and the next request is
//   accepted; its result waits until the held one is taken.
// ----------------------------------------------------------------------------
module multi_timebase_on_delay_timer_bank_top #(
  parameter int TIMERS_PER_BANK = 16
) (
  input  logic       clk,
  input  logic       rst,
  mtdt_req_if.sink   req,
  mtdt_rsp_if.source rsp,
  mtdt_cfg_if.sink   cfg
);
  import mtdt_pkg::*;

  logic          tick_take;
  prescale_hit_t hits;

  // Prescalers and limit registers
  mtdt_prescale u_prescale (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .tick_take (tick_take),
    .hits      (hits)
  );

  // Timer store and request sequencer
  mtdt_seq #(
    .TIMERS_PER_BANK (TIMERS_PER_BANK)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .rsp       (rsp),
    .hits      (hits),
    .tick_take (tick_take)
  );

endmodule

FILE: tb/timer_bank_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// timer_bank_checker: predicts and checks the on-delay timer bank
// Watches the request, response and configuration channels, keeps its own
// copy of the timers, prescalers and limits, and compares every response
// with the readback expected for the oldest open request.
// ----------------------------------------------------------------------------
module timer_bank_checker
  import mtdt_pkg::*;
#(
  parameter int TIMERS_PER_BANK = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  input  logic                 req_ready,
  input  logic [REQ_W-1:0]     req_type,
  input  logic [BANK_W-1:0]    bank_sel,
  input  logic [TIDX_W-1:0]    timer_index,
  input  logic [PRESET_W-1:0]  preset_value,
  input  logic                 rsp_valid,
  input  logic                 rsp_ready,
  input  logic                 rsp_done,
  input  logic [COUNT_W-1:0]   rsp_count,
  input  logic                 rsp_running,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [LIMIT_W-1:0]   cfg_data,
  output int unsigned          mismatches,
  output int unsigned          awaiting
);

  localparam int SLOTS = NUM_BANKS * TIMERS_PER_BANK;

  timer_entry_t       timers [SLOTS];
  logic [LIMIT_W-1:0] bank_limit [1:NUM_BANKS-1];
  logic [LIMIT_W-1:0] prescaler [1:NUM_BANKS-1];
  timer_result_t      expected_readback [$];
  timer_result_t      want;

  initial begin
    mismatches = 0;
    awaiting   = 0;
  end

  task automatic report_mismatch(string msg);
    $display("%0t mismatch: %s", $realtime, msg);
    mismatches++;
  endtask

  // Advance every enabled timer of one bank by one timebase step
  function automatic void step_bank(int bank);
    int slot;
    int cnt_val;
    int pre_val;
    for (int k = 0; k < TIMERS_PER_BANK; k++) begin
      slot = bank * TIMERS_PER_BANK + k;
      if (timers[slot].enable) begin
        cnt_val = timers[slot].count;
        pre_val = int'($signed(timers[slot].preset));
        if (timers[slot].count == COUNT_MAX) begin
          // saturated: count holds, done drops
          timers[slot].done = 1'b0;
        end else begin
          timers[slot].done  = (cnt_val >= pre_val);
          timers[slot].count = timers[slot].count + 1'b1;
        end
      end
    end
  endfunction

  // Apply one request to the local state and return the expected readback
  function automatic timer_result_t apply_request(logic [REQ_W-1:0]    kind,
                                                  logic [BANK_W-1:0]   bank,
                                                  logic [TIDX_W-1:0]   idx,
                                                  logic [PRESET_W-1:0] preset);
    timer_result_t r;
    int            slot;
    r = '0;
    if (kind == REQ_TICK) begin
      step_bank(0);
      for (int b = 1; b < NUM_BANKS; b++) begin
        if (prescaler[b] >= bank_limit[b]) begin
          step_bank(b);
          prescaler[b] = '0;
        end
      end
      for (int b = 1; b < NUM_BANKS; b++) begin
        prescaler[b] = prescaler[b] + 1'b1;
      end
    end else if (int'(idx) < TIMERS_PER_BANK) begin
      slot = int'(bank) * TIMERS_PER_BANK + int'(idx);
      case (kind)
        REQ_START: begin
          if (!timers[slot].enable) begin
            timers[slot].preset = preset;
            timers[slot].count  = '0;
            timers[slot].enable = 1'b1;
            timers[slot].done   = 1'b0;
          end
        end
        REQ_STOP: begin
          if (timers[slot].enable) begin
            timers[slot].enable = 1'b0;
            timers[slot].done   = 1'b0;
          end
        end
        default: ;
      endcase
      r.done    = timers[slot].done;
      r.count   = timers[slot].count;
      r.running = timers[slot].enable;
    end
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      // clear the local copy of the block
      for (int s = 0; s < SLOTS; s++) begin
        timers[s] = '0;
      end
      for (int b = 1; b < NUM_BANKS; b++) begin
        prescaler[b] = '0;
      end
      bank_limit[1] = LIMIT1_RST;
      bank_limit[2] = LIMIT2_RST;
      bank_limit[3] = LIMIT3_RST;
      expected_readback.delete();
    end else begin
      // check a response before adding the request of this edge
      if (rsp_valid && rsp_ready) begin
        if (expected_readback.size() == 0) begin
          report_mismatch($sformatf("response with no open request (done %0b count %0d run %0b)",
                                    rsp_done, rsp_count, rsp_running));
        end else begin
          want = expected_readback.pop_front();
          if (rsp_done !== want.done)
            report_mismatch($sformatf("timer_done got %0b want %0b", rsp_done, want.done));
          if (rsp_count !== want.count)
            report_mismatch($sformatf("timer_count got %0d want %0d", rsp_count, want.count));
          if (rsp_running !== want.running)
            report_mismatch($sformatf("timer_running got %0b want %0b",
                                      rsp_running, want.running));
        end
      end

      // track limit writes
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_LIMIT1: bank_limit[1] = cfg_data;
          CFG_LIMIT2: bank_limit[2] = cfg_data;
          CFG_LIMIT3: bank_limit[3] = cfg_data;
          default: ;
        endcase
      end

      // predict the accepted request
      if (req_valid && req_ready) begin
        expected_readback.push_back(apply_request(req_type, bank_sel, timer_index,
                                                  preset_value));
      end
    end
    awaiting = expected_readback.size();
  end

endmodule

FILE: tb/tb_multi_timebase_on_delay_timer_bank_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_multi_timebase_on_delay_timer_bank_top: stimulus for the timer bank
// Runs a directed sequence at the reset limits, then several limit settings
// with random tick, start, stop and read requests, random idling on both
// channels, and gives the verdict from the checker's mismatch count.
// ----------------------------------------------------------------------------
module tb_multi_timebase_on_delay_timer_bank_top;
  import mtdt_pkg::*;

  localparam int TIMERS_PER_BANK = 16;
  localparam int PHASES          = 6;
  localparam int PHASE_ITEMS     = 171;
  // no register sits at this index
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  int unsigned mismatches;
  int unsigned awaiting;
  bit          calm;
  int          idle_odds;
  int          stall_left;

  mtdt_req_if req_if ();
  mtdt_rsp_if rsp_if ();
  mtdt_cfg_if cfg_if ();

  multi_timebase_on_delay_timer_bank_top #(
    .TIMERS_PER_BANK(TIMERS_PER_BANK)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .req(req_if.sink),
    .rsp(rsp_if.source),
    .cfg(cfg_if.sink)
  );

  timer_bank_checker #(
    .TIMERS_PER_BANK(TIMERS_PER_BANK)
  ) u_checker (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_if.valid),
    .req_ready   (req_if.ready),
    .req_type    (req_if.req_type),
    .bank_sel    (req_if.bank_sel),
    .timer_index (req_if.timer_index),
    .preset_value(req_if.preset_value),
    .rsp_valid   (rsp_if.valid),
    .rsp_ready   (rsp_if.ready),
    .rsp_done    (rsp_if.timer_done),
    .rsp_count   (rsp_if.timer_count),
    .rsp_running (rsp_if.timer_running),
    .cfg_valid   (cfg_if.valid),
    .cfg_ready   (cfg_if.ready),
    .cfg_index   (cfg_if.index),
    .cfg_data    (cfg_if.data),
    .mismatches  (mismatches),
    .awaiting    (awaiting)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Stall the response channel in random bursts
  always @(negedge clk) begin
    if (calm || idle_odds == 0) begin
      stall_left = 0;
      rsp_if.ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      rsp_if.ready <= 1'b0;
    end else if ($urandom_range(0, idle_odds) == 0) begin
      stall_left = $urandom_range(1, 19) - 1;
      rsp_if.ready <= 1'b0;
    end else begin
      rsp_if.ready <= 1'b1;
    end
  end

  // Issue one request, with a random gap ahead of it
  task automatic send_request(logic [REQ_W-1:0] kind, logic [BANK_W-1:0] bank,
                              logic [TIDX_W-1:0] idx, logic [PRESET_W-1:0] preset);
    int gap;
    gap = 0;
    if (!calm && idle_odds != 0 && $urandom_range(0, idle_odds) == 0)
      gap = $urandom_range(1, 19);
    repeat (gap) begin
      @(negedge clk);
      req_if.valid <= 1'b0;
    end
    @(negedge clk);
    req_if.valid        <= 1'b1;
    req_if.req_type     <= kind;
    req_if.bank_sel     <= bank;
    req_if.timer_index  <= idx;
    req_if.preset_value <= preset;
    do @(posedge clk); while (req_if.ready !== 1'b1);
  endtask

  // Drop valid and hold until every open request has its response
  task automatic drain_results();
    @(negedge clk);
    req_if.valid <= 1'b0;
    while (awaiting != 0) @(negedge clk);
  endtask

  task automatic write_register(logic [CFG_IDX_W-1:0] index, logic [LIMIT_W-1:0] data);
    @(negedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= index;
    cfg_if.data  <= data;
    do @(posedge clk); while (cfg_if.ready !== 1'b1);
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  initial begin
    logic [LIMIT_W-1:0]  lim1;
    logic [LIMIT_W-1:0]  lim2;
    logic [LIMIT_W-1:0]  lim3;
    logic [REQ_W-1:0]    kind;
    logic [PRESET_W-1:0] preset;
    int                  roll;

    calm                = 1'b0;
    idle_odds           = 0;
    stall_left          = 0;
    req_if.valid        = 1'b0;
    req_if.req_type     = REQ_TICK;
    req_if.bank_sel     = '0;
    req_if.timer_index  = '0;
    req_if.preset_value = '0;
    rsp_if.ready        = 1'b1;
    cfg_if.valid        = 1'b0;
    cfg_if.index        = CFG_LIMIT1;
    cfg_if.data         = '0;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: reset limits, corner presets, ignored start and stop
    send_request(REQ_READ,  2'd0, 4'd0,  16'h0000);
    send_request(REQ_START, 2'd0, 4'd0,  16'd3);
    send_request(REQ_START, 2'd0, 4'd0,  16'd9);
    send_request(REQ_START, 2'd3, 4'd15, 16'h8000);
    send_request(REQ_START, 2'd1, 4'd5,  16'h7FFF);
    send_request(REQ_START, 2'd2, 4'd10, 16'h0000);
    send_request(REQ_STOP,  2'd2, 4'd11, 16'hFFFF);
    repeat (5) send_request(REQ_TICK, 2'd0, 4'd0, 16'h0000);
    send_request(REQ_READ,  2'd0, 4'd0,  16'h0000);
    send_request(REQ_STOP,  2'd0, 4'd0,  16'h0000);
    send_request(REQ_READ,  2'd0, 4'd0,  16'h0000);
    send_request(REQ_START, 2'd0, 4'd0,  16'hFFFF);
    send_request(REQ_TICK,  2'd3, 4'd15, 16'h7FFF);
    send_request(REQ_READ,  2'd0, 4'd0,  16'h0000);
    repeat (5) send_request(REQ_TICK, 2'd0, 4'd0, 16'h0000);
    send_request(REQ_READ,  2'd1, 4'd5,  16'h0000);
    send_request(REQ_STOP,  2'd3, 4'd15, 16'h0000);
    send_request(REQ_READ,  2'd3, 4'd15, 16'h0000);

    for (int p = 0; p < PHASES; p++) begin
      // settle the block before touching the limits
      drain_results();
      repeat (4) @(negedge clk);
      case (p)
        0: begin lim1 = 12'd1;    lim2 = 12'd1;    lim3 = 12'd1;    end
        1: begin lim1 = 12'd0;    lim2 = 12'd2;    lim3 = 12'd5;    end
        2: begin lim1 = 12'd4095; lim2 = 12'd4095; lim3 = 12'd4095; end
        3: begin lim1 = 12'd3;    lim2 = 12'd7;    lim3 = 12'd20;   end
        4: begin lim1 = LIMIT1_RST; lim2 = LIMIT2_RST; lim3 = LIMIT3_RST; end
        default: begin
          lim1 = 12'($urandom_range(0, 15));
          lim2 = 12'($urandom_range(0, 15));
          lim3 = 12'($urandom_range(0, 15));
        end
      endcase
      write_register(CFG_LIMIT1, lim1);
      write_register(CFG_LIMIT2, lim2);
      write_register(CFG_LIMIT3, lim3);
      if (p == 2)
        write_register(CFG_UNUSED, 12'hFFF);

      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // pick a new idling rate for each stretch, sometimes none at all
        if (n % 35 == 0) begin
          case ($urandom_range(0, 2))
            0:       idle_odds = 0;
            1:       idle_odds = 2;
            default: idle_odds = 6;
          endcase
        end
        if (p == PHASES - 1 && n >= PHASE_ITEMS - 80)
          calm = 1'b1;
        if ($urandom_range(0, 60) == 0)
          drain_results();

        roll = $urandom_range(0, 99);
        if (roll < 40)      kind = REQ_TICK;
        else if (roll < 62) kind = REQ_START;
        else if (roll < 77) kind = REQ_STOP;
        else                kind = REQ_READ;

        roll = $urandom_range(0, 19);
        if (roll < 14) begin
          preset = 16'($urandom_range(0, 45)) - 16'd5;
        end else if (roll < 17) begin
          preset = 16'($urandom);
        end else begin
          case ($urandom_range(0, 4))
            0:       preset = 16'h8000;
            1:       preset = 16'h7FFF;
            2:       preset = 16'hFFFF;
            3:       preset = 16'h0001;
            default: preset = 16'h0000;
          endcase
        end
        send_request(kind, 2'($urandom_range(0, 3)), 4'($urandom_range(0, 15)), preset);
      end
    end

    // Wait out the last responses, then give the verdict
    drain_results();
    repeat (100) @(posedge clk);
    if (mismatches == 0 && awaiting == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #8_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule

FILE: multi_timebase_on_delay_timer_bank_top.f
design/mtdt_pkg.sv
design/mtdt_if.sv
design/mtdt_ram.sv
design/mtdt_prescale.sv
design/mtdt_seq.sv
design/multi_timebase_on_delay_timer_bank_top.sv
tb/timer_bank_checker.sv
tb/tb_multi_timebase_on_delay_timer_bank_top.sv
